// ===== hw/rtl/fcrc_pkg.sv =====
// Shared types, constants and the byte-wide CRC-32 step for the trailer inserter.
`default_nettype none

package fcrc_pkg;

	localparam int unsigned POS_W = 17;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	localparam logic [POS_W-1:0] HEADER_BYTES     = 17'd16;
	localparam logic [POS_W-1:0] SIZE_FIELD_START = 17'd12;
	localparam logic [POS_W-1:0] SIZE_FIELD_LAST  = 17'd15;

	localparam logic [31:0] MIN_PAYLOAD_BYTES = 32'd8;
	localparam logic [31:0] MAX_PAYLOAD_BYTES = 32'd65536;

	// Offsets from P that bound the CRC span, the trailer and the final byte.
	localparam logic [POS_W-1:0] CRC_SPAN_END  = 17'd8;
	localparam logic [POS_W-1:0] TRAILER_END   = 17'd12;
	localparam logic [POS_W-1:0] LAST_BYTE_OFS = 17'd15;

	localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
	localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

	// Trailer byte order: most significant CRC byte first.
	localparam logic [1:0] TRL_B3 = 2'd0;
	localparam logic [1:0] TRL_B2 = 2'd1;
	localparam logic [1:0] TRL_B1 = 2'd2;

	typedef struct packed {
		logic       emit;
		logic [7:0] data;
		logic       last;
		logic       err;
	} fcrc_res_t;

	typedef struct packed {
		logic span_done;
		logic size_bad;
		logic at_start;
	} fcrc_stat_t;

	// Reflected CRC-32, one byte, unrolled over its eight bits.
	function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
		logic [31:0] c;
		c = c_in ^ {24'd0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fcrc_frame_ctl.sv =====
// Frame position tracking, size check, CRC accumulation and trailer substitution.
`default_nettype none

module fcrc_frame_ctl
	import fcrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       advance,   // beat in this cycle is consumed
	input  wire logic [7:0] beat_byte,
	input  wire logic       beat_last,
	output fcrc_res_t       res,
	output fcrc_stat_t      stat
);

	logic [POS_W-1:0] pos_q, pos_n;
	logic [31:0]      size_q, size_n;
	logic [31:0]      crc_q, crc_n, crc_upd, crc_inv;
	logic             bad_q, bad_n;
	logic             done_q, done_n;

	logic [POS_W-1:0] p, p_crc_end, p_trl_end, p_last;
	logic [POS_W-1:0] trl_ofs;
	logic             in_header;

	assign p         = size_q[POS_W-1:0];
	assign p_crc_end = p + CRC_SPAN_END;
	assign p_trl_end = p + TRAILER_END;
	assign p_last    = p + LAST_BYTE_OFS;
	assign trl_ofs   = pos_q - p_crc_end;
	assign in_header = pos_q < HEADER_BYTES;
	assign crc_upd   = crc_byte(crc_q, beat_byte);
	assign crc_inv   = ~crc_q;

	always_comb begin
		res.emit = !done_q;
		res.data = beat_byte;
		res.last = 1'b0;
		res.err  = 1'b0;
		size_n   = size_q;
		crc_n    = crc_q;
		bad_n    = bad_q;
		done_n   = done_q;
		pos_n    = (pos_q != POS_MAX) ? pos_q + 1'b1 : pos_q;

		if (done_q) begin
			pos_n = pos_q;
		end else if (in_header) begin
			if (pos_q >= SIZE_FIELD_START) begin
				size_n = {size_q[23:0], beat_byte};
			end
			crc_n = crc_upd;
			if (pos_q == SIZE_FIELD_LAST) begin
				bad_n   = (size_n < MIN_PAYLOAD_BYTES) || (size_n > MAX_PAYLOAD_BYTES);
				res.err = bad_n;
			end
		end else if (bad_q) begin
			res.err = 1'b1;
		end else if (pos_q < p_crc_end) begin
			crc_n = crc_upd;
		end else if (pos_q < p_trl_end) begin
			case (trl_ofs[1:0])
				TRL_B3:  res.data = crc_inv[31:24];
				TRL_B2:  res.data = crc_inv[23:16];
				TRL_B1:  res.data = crc_inv[15:8];
				default: res.data = crc_inv[7:0];
			endcase
		end else if (pos_q == p_last) begin
			res.last = 1'b1;
			done_n   = 1'b1;
		end

		// frame_end restarts the block for the next frame
		if (beat_last) begin
			res.last = 1'b1;
			pos_n    = '0;
			size_n   = '0;
			crc_n    = CRC_INIT;
			bad_n    = 1'b0;
			done_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			size_q <= '0;
			crc_q  <= CRC_INIT;
			bad_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (advance) begin
			pos_q  <= pos_n;
			size_q <= size_n;
			crc_q  <= crc_n;
			bad_q  <= bad_n;
			done_q <= done_n;
		end
	end

	assign stat.span_done = done_q;
	assign stat.size_bad  = bad_q;
	assign stat.at_start  = (pos_q == '0);

endmodule

`default_nettype wire

// ===== hw/rtl/frame_crc32_trailer_inserter_core.sv =====
// Top level: frame CRC-32 trailer inserter with input and result registers.
`default_nettype none

//  channel | dir | tdata (low bit up) | tlast     | tuser
//  s_*     | in  | in_byte[7:0]       | frame_end | -
//  m_*     | out | out_byte[7:0]      | out_last  | length_error
//
//  One beat per cycle sustained while m_tready stays high.
//  Input beats land in the _s1 register, the CRC/trailer logic between the
//  stages is combinational, and the result lands in the _s2 output register.
//  Beats dropped after byte P+15 retire from _s1 without touching _s2.
//  A stalled m_ side holds _s2; _s1 still loads while _s2 waits, so s_tready
//  drops only when both stages are full. arst_n clears all frame state.

module frame_crc32_trailer_inserter_core
	import fcrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output      logic       s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic       s_tlast,   // frame_end
	output      logic       m_tvalid,
	input  wire logic       m_tready,
	output      logic [7:0] m_tdata,   // [7:0] out_byte
	output      logic       m_tlast,   // out_last
	output      logic       m_tuser    // [0] length_error
);

	// input stage
	logic       beat_valid_s1;
	logic [7:0] beat_byte_s1;
	logic       beat_last_s1;

	// result stage
	logic       out_valid_s2;
	logic [7:0] out_byte_s2;
	logic       out_last_s2;
	logic       out_err_s2;

	fcrc_res_t  res;
	fcrc_stat_t stat;
	logic       out_free;
	logic       consume;

	assign out_free = !out_valid_s2 || m_tready;
	// a beat that yields no result retires even while the output waits
	assign consume  = beat_valid_s1 && (!res.emit || out_free);
	assign s_tready = !beat_valid_s1 || consume;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			beat_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			beat_byte_s1 <= s_tdata;
			beat_last_s1 <= s_tlast;
		end
	end

	fcrc_frame_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (consume),
		.beat_byte (beat_byte_s1),
		.beat_last (beat_last_s1),
		.res       (res),
		.stat      (stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (consume && res.emit) begin
			out_valid_s2 <= 1'b1;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (consume && res.emit) begin
			out_byte_s2 <= res.data;
			out_last_s2 <= res.last;
			out_err_s2  <= res.err;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = out_byte_s2;
	assign m_tlast  = out_last_s2;
	assign m_tuser  = out_err_s2;

	// An empty input stage always takes a beat.
	a_s1_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!beat_valid_s1 |-> s_tready)
		else $error("input stage empty but s_tready low");

	// The span can only close on a frame whose size passed the check.
	a_done_implies_good: assert property (@(posedge clk) disable iff (!arst_n)
		stat.span_done |-> !stat.size_bad)
		else $error("span closed on a bad-size frame");

	// frame_end returns the position counter to the frame start.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		consume && beat_last_s1 |=> stat.at_start)
		else $error("frame_end did not restart the frame");

	// A produced result is presented on the next cycle.
	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		consume && res.emit |=> m_tvalid)
		else $error("result lost between stages");

endmodule

`default_nettype wire
